// File: rtl/assert_macros.svh
// Assertion macros for RTL that carries concurrent checks; the core is their only user.
// No dependencies; take it in by `include where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PDD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("pdd check failed");

// Check that a condition implies another in the same cycle.
`define PDD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    `PDD_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

// File: rtl/pdd_pkg.sv
// Shared constants, types and config codes of the peak detect decimator.
// No dependencies; used by every RTL module and interface through scoped names.
package pdd_pkg;

    localparam int SampleW = 16;
    localparam int CountW  = 16;
    localparam int MagW    = SampleW + 1;
    localparam int MaxRun  = 64;
    localparam int CntW    = $clog2(MaxRun);
    localparam int LimW    = CountW + CntW;
    localparam int ProdW   = 2 * CountW;
    localparam int AccW    = ProdW + 1;
    localparam int IdxW    = 2;
    localparam int DataW   = CountW;
    localparam int QDepth  = 2;
    localparam int QAw     = $clog2(QDepth);

    // Config register indexes
    typedef enum logic [IdxW-1:0] {
        CfgMode     = 2'd0,
        CfgInCount  = 2'd1,
        CfgOutCount = 2'd2
    } t_cfg_idx;

    // Effective configuration seen by the datapath
    typedef struct packed {
        logic              mode;
        logic [CountW-1:0] n;
        logic [CountW-1:0] t;
    } t_cfg;

    // One classified sample on its way from front to back
    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic [MagW-1:0]           mag;
        logic [ProdW-1:0]          it;
        logic [AccW-1:0]           it2;
        logic                      series_end;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic signed [SampleW-1:0] value;
        logic [CountW-1:0]         bin_index;
        logic                      last;
    } t_result;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

    typedef struct packed {
        logic cont;
        logic step;
        logic emit;
        logic out_stall;
    } t_back_status;

endpackage

// File: rtl/pdd_in_if.sv
// Input sample channel: valid/ready handshake plus one signed sample.
// Depends on pdd_pkg for the sample width.
interface pdd_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pdd_pkg::SampleW-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// File: rtl/pdd_out_if.sv
// Result channel: valid/ready handshake plus picked value, bin index and last flag.
// Depends on pdd_pkg for the field widths.
interface pdd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pdd_pkg::SampleW-1:0] value;
    logic [pdd_pkg::CountW-1:0]         bin_index;
    logic                               last;

    modport source (output valid, output value, output bin_index, output last, input ready);
    modport sink (input valid, input value, input bin_index, input last, output ready);
endinterface

// File: rtl/peak_detect_decimator_core.sv
// Peak detect decimator: a series of in_count signed samples enters on i_in and
// out_count bin results leave on o_out, each the maximum (mode 0) or the first
// largest-magnitude sample (mode 1) of its bin, tagged with its bin index.
// Both channels use valid/ready; a transaction moves when both are high.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 mode,
// 1 in_count, 2 out_count); any valid write restarts the series and holds
// i_in.ready low for one cycle.
// A taken sample is queued; the back end loads its result into the register that drives o_out.
// Throughput: one sample per cycle while each sample closes at most one bin and
// o_out is not stalled; a sample that closes more bins stays at the queue head,
// one result per cycle, and the two-entry queue then fills and holds i_in.ready low.
// A stalled o_out freezes its result register; the back end stops at the next
// sample that closes a bin, and the front keeps taking samples until the queue is full.
// Reset: synchronous active-low i_rst_n sets mode 0, in_count 1, out_count 1,
// empties the queue and clears all series state.
// Depends on pdd_pkg, pdd_in_if, pdd_out_if, pdd_cfg, pdd_front, pdd_fifo,
// pdd_back and assert_macros.svh.
`include "assert_macros.svh"

module peak_detect_decimator_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pdd_pkg::IdxW-1:0]   i_cfg_index,
    input  logic [pdd_pkg::DataW-1:0]  i_cfg_data,
    pdd_in_if.sink                     i_in,
    pdd_out_if.source                  o_out
);

    pdd_pkg::t_cfg         cfg;
    logic                  restart;
    logic                  push;
    logic                  pop;
    pdd_pkg::t_item        item;
    pdd_pkg::t_item        head;
    pdd_pkg::t_q_status    q_status;
    pdd_pkg::t_back_status b_status;

    pdd_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (i_cfg_we),
        .i_index   (i_cfg_index),
        .i_data    (i_cfg_data),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    pdd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (restart),
        .i_q_full  (q_status.full),
        .i_in      (i_in),
        .o_push    (push),
        .o_item    (item)
    );

    pdd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (item),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    pdd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_restart    (restart),
        .i_head_valid (q_status.valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_status     (b_status),
        .o_out        (o_out)
    );

    // A bin run in progress always has its sample at the queue head
    `PDD_ASSERT_IMP(a_cont_has_head, i_clk, i_rst_n, b_status.cont, q_status.valid)
    // Never take a sample into a full queue
    `PDD_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, q_status.full, !push)
    // A stalled result register blocks any further emission
    `PDD_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n, b_status.out_stall && b_status.step,
                    !b_status.emit)
    // A run that continues starts from a result already in the register
    `PDD_ASSERT(a_cont_after_emit, i_clk, i_rst_n, $rose(b_status.cont) |-> o_out.valid)

endmodule

// File: rtl/pdd_cfg.sv
// Config register bank: holds mode, effective sample count and clipped bin count.
// Depends on pdd_pkg; issues a one-cycle restart after every valid write.
module pdd_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [pdd_pkg::IdxW-1:0]   i_index,
    input  logic [pdd_pkg::DataW-1:0]  i_data,
    output pdd_pkg::t_cfg              o_cfg,
    output logic                       o_restart
);

    logic                        r_mode, n_mode;
    logic [pdd_pkg::CountW-1:0]  r_n, n_n;
    logic [pdd_pkg::CountW-1:0]  r_out, n_out;
    logic [pdd_pkg::CountW-1:0]  r_t, n_t;
    logic                        r_restart, n_restart;
    logic [pdd_pkg::LimW-1:0]    lim;

    // Map a zero count to one
    function automatic logic [pdd_pkg::CountW-1:0] eff(input logic [pdd_pkg::CountW-1:0] v);
        eff = (v == '0) ? pdd_pkg::CountW'(1) : v;
    endfunction

    // Decode the write and clip the bin count to the run limit
    always_comb begin
        n_mode    = r_mode;
        n_n       = r_n;
        n_out     = r_out;
        n_restart = 1'b0;
        if (i_we) begin
            case (pdd_pkg::t_cfg_idx'(i_index))
                pdd_pkg::CfgMode: begin
                    n_mode    = i_data[0];
                    n_restart = 1'b1;
                end
                pdd_pkg::CfgInCount: begin
                    n_n       = eff(i_data[pdd_pkg::CountW-1:0]);
                    n_restart = 1'b1;
                end
                pdd_pkg::CfgOutCount: begin
                    n_out     = eff(i_data[pdd_pkg::CountW-1:0]);
                    n_restart = 1'b1;
                end
                default: begin
                    n_restart = 1'b0;
                end
            endcase
        end
        lim = pdd_pkg::LimW'(n_n) * pdd_pkg::LimW'(pdd_pkg::MaxRun);
        n_t = (pdd_pkg::LimW'(n_out) > lim) ? lim[pdd_pkg::CountW-1:0] : n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_n       <= pdd_pkg::CountW'(1);
            r_out     <= pdd_pkg::CountW'(1);
            r_t       <= pdd_pkg::CountW'(1);
            r_restart <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_n       <= n_n;
            r_out     <= n_out;
            r_t       <= n_t;
            r_restart <= n_restart;
        end
    end

    assign o_cfg.mode = r_mode;
    assign o_cfg.n    = r_n;
    assign o_cfg.t    = r_t;
    assign o_restart  = r_restart;

endmodule

// File: rtl/pdd_front.sv
// Front end: accepts samples, tracks series position and the bound products.
// Depends on pdd_pkg and pdd_in_if; feeds classified items to the queue.
module pdd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdd_pkg::t_cfg     i_cfg,
    input  logic              i_restart,
    input  logic              i_q_full,
    pdd_in_if.sink            i_in,
    output logic              o_push,
    output pdd_pkg::t_item    o_item
);

    logic [pdd_pkg::CountW-1:0]  r_i, n_i;
    logic [pdd_pkg::ProdW-1:0]   r_it, n_it;
    logic [pdd_pkg::CountW:0]    i_next;
    logic                        series_end;
    logic [pdd_pkg::MagW-1:0]    s_ext;

    // Stall while the queue is full or a restart is settling
    assign i_in.ready = !i_q_full && !i_restart;
    assign o_push     = i_in.valid && i_in.ready;

    // Classify the sample: magnitude, position products and series end
    always_comb begin
        s_ext      = {i_in.sample[pdd_pkg::SampleW-1], i_in.sample};
        i_next     = {1'b0, r_i} + (pdd_pkg::CountW+1)'(1);
        series_end = i_next >= {1'b0, i_cfg.n};

        o_item.sample     = i_in.sample;
        o_item.mag        = s_ext[pdd_pkg::MagW-1] ? (~s_ext + pdd_pkg::MagW'(1)) : s_ext;
        o_item.it         = r_it;
        o_item.it2        = pdd_pkg::AccW'(r_it) + pdd_pkg::AccW'({i_cfg.t, 1'b0});
        o_item.series_end = series_end;

        n_i  = r_i;
        n_it = r_it;
        if (i_restart) begin
            n_i  = '0;
            n_it = '0;
        end else if (o_push) begin
            n_i  = series_end ? '0 : i_next[pdd_pkg::CountW-1:0];
            n_it = series_end ? '0 : r_it + pdd_pkg::ProdW'(i_cfg.t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i  <= '0;
            r_it <= '0;
        end else begin
            r_i  <= n_i;
            r_it <= n_it;
        end
    end

endmodule

// File: rtl/pdd_fifo.sv
// Short item queue between front and back.
// Depends on pdd_pkg for the item type and depth.
module pdd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pdd_pkg::t_item      i_item,
    input  logic                i_pop,
    output pdd_pkg::t_item      o_head,
    output pdd_pkg::t_q_status  o_status
);

    pdd_pkg::t_item           r_mem [pdd_pkg::QDepth];
    logic [pdd_pkg::QAw-1:0]  r_wp, n_wp;
    logic [pdd_pkg::QAw-1:0]  r_rp, n_rp;
    logic [pdd_pkg::QAw:0]    r_cnt, n_cnt;
    logic                     do_pop;

    // Advance pointers, wrapping at the depth
    always_comb begin
        do_pop = i_pop && (r_cnt != '0);
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == pdd_pkg::QAw'(pdd_pkg::QDepth - 1)) ? '0 : r_wp + pdd_pkg::QAw'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == pdd_pkg::QAw'(pdd_pkg::QDepth - 1)) ? '0 : r_rp + pdd_pkg::QAw'(1);
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + (pdd_pkg::QAw+1)'(1);
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - (pdd_pkg::QAw+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_head         = r_mem[r_rp];
    assign o_status.full  = r_cnt == (pdd_pkg::QAw+1)'(pdd_pkg::QDepth);
    assign o_status.valid = r_cnt != '0;

endmodule

// File: rtl/pdd_back.sv
// Back end: updates the bin pick and emits one result per cycle into an output register unless o_out stalls.
// Depends on pdd_pkg and pdd_out_if; pops items from the queue when they are finished.
module pdd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pdd_pkg::t_cfg         i_cfg,
    input  logic                  i_restart,
    input  logic                  i_head_valid,
    input  pdd_pkg::t_item        i_head,
    output logic                  o_pop,
    output pdd_pkg::t_back_status o_status,
    pdd_out_if.source             o_out
);

    logic [pdd_pkg::AccW-1:0]          r_acc, n_acc;
    logic [pdd_pkg::CountW-1:0]        r_bin, n_bin;
    logic signed [pdd_pkg::SampleW-1:0] r_pick, n_pick;
    logic [pdd_pkg::MagW-1:0]          r_mag, n_mag;
    logic [pdd_pkg::CntW-1:0]          r_cnt, n_cnt;
    logic                              r_cont, n_cont;
    logic                              r_out_valid, n_out_valid;
    pdd_pkg::t_result                  r_out, n_out;

    logic                              fresh;
    logic signed [pdd_pkg::SampleW-1:0] pick_upd;
    logic [pdd_pkg::MagW-1:0]          mag_upd;
    logic                              emit, more, step, done, out_load;
    logic [pdd_pkg::AccW-1:0]          n_ext, acc_nx;
    logic [pdd_pkg::CntW:0]            cnt_ext;
    logic [pdd_pkg::CountW:0]          bin_ext;

    always_comb begin
        n_ext   = pdd_pkg::AccW'(i_cfg.n);
        acc_nx  = r_acc + n_ext;
        cnt_ext = {1'b0, r_cnt};
        bin_ext = {1'b0, r_bin};

        // Open a new bin on the first sample at or past its start
        fresh = !r_cont &&
                ((r_acc < n_ext) || ((r_acc - n_ext) >= pdd_pkg::AccW'(i_head.it)));

        pick_upd = r_pick;
        mag_upd  = r_mag;
        if (!r_cont) begin
            if (fresh) begin
                pick_upd = i_head.sample;
                mag_upd  = i_head.mag;
            end else if (!i_cfg.mode) begin
                if (i_head.sample > r_pick) begin
                    pick_upd = i_head.sample;
                    mag_upd  = i_head.mag;
                end
            end else if (i_head.mag > r_mag) begin
                pick_upd = i_head.sample;
                mag_upd  = i_head.mag;
            end
        end

        // Close a bin now, and look ahead for one more from this sample
        emit = (cnt_ext < (pdd_pkg::CntW+1)'(pdd_pkg::MaxRun)) &&
               (bin_ext < (pdd_pkg::CountW+1)'(i_cfg.t)) &&
               (r_acc < i_head.it2);
        more = ((cnt_ext + (pdd_pkg::CntW+1)'(1)) < (pdd_pkg::CntW+1)'(pdd_pkg::MaxRun)) &&
               ((bin_ext + (pdd_pkg::CountW+1)'(1)) < (pdd_pkg::CountW+1)'(i_cfg.t)) &&
               (acc_nx < i_head.it2);

        out_load = !r_out_valid || o_out.ready;
        step     = i_head_valid && (!emit || out_load);
        done     = !emit || !more;
        o_pop    = step && done;

        n_acc       = r_acc;
        n_bin       = r_bin;
        n_pick      = r_pick;
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_cont      = r_cont;
        n_out       = r_out;
        n_out_valid = out_load ? 1'b0 : r_out_valid;

        if (step) begin
            if (emit) begin
                n_out.value     = pick_upd;
                n_out.bin_index = r_bin;
                n_out.last      = !more;
                n_out_valid     = 1'b1;
                n_acc           = acc_nx;
                n_bin           = r_bin + pdd_pkg::CountW'(1);
                n_pick          = i_head.sample;
                n_mag           = i_head.mag;
            end else begin
                n_pick = pick_upd;
                n_mag  = mag_upd;
            end
            if (done) begin
                n_cont = 1'b0;
                n_cnt  = '0;
                // Restart the series after its final sample
                if (i_head.series_end) begin
                    n_acc  = n_ext;
                    n_bin  = '0;
                    n_pick = '0;
                    n_mag  = '0;
                end
            end else begin
                n_cont = 1'b1;
                n_cnt  = r_cnt + pdd_pkg::CntW'(1);
            end
        end

        if (i_restart) begin
            n_acc  = n_ext;
            n_bin  = '0;
            n_pick = '0;
            n_mag  = '0;
            n_cnt  = '0;
            n_cont = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= pdd_pkg::AccW'(1);
            r_bin       <= '0;
            r_pick      <= '0;
            r_mag       <= '0;
            r_cnt       <= '0;
            r_cont      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_bin       <= n_bin;
            r_pick      <= n_pick;
            r_mag       <= n_mag;
            r_cnt       <= n_cnt;
            r_cont      <= n_cont;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.value     = r_out.value;
    assign o_out.bin_index = r_out.bin_index;
    assign o_out.last      = r_out.last;

    assign o_status.cont      = r_cont;
    assign o_status.step      = step;
    assign o_status.emit      = emit;
    assign o_status.out_stall = !out_load;

endmodule

// File: tb/sv/tb_peak_detect_decimator_core.sv
// Self-checking testbench for peak_detect_decimator_core: directed and random sample series,
// each result checked against a cycle-free predictor of the bin picks.
// Depends on pdd_pkg, pdd_in_if, pdd_out_if and the core RTL.
module tb_peak_detect_decimator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pdd_pkg::IdxW-1:0] CfgSpare = 2'd3;
    localparam int SettleCycles     = 6;
    localparam int DrainLimit       = 50000;
    localparam int HoldCycles       = 400;
    localparam int MaxReports       = 10;
    localparam int RandomItems      = 90;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [pdd_pkg::IdxW-1:0]    i_cfg_index;
    logic [pdd_pkg::DataW-1:0]   i_cfg_data;

    pdd_in_if  sample_ch ();
    pdd_out_if bin_ch ();

    peak_detect_decimator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (sample_ch),
        .o_out       (bin_ch)
    );

    // Predictor copy of the configuration and series state
    logic                  mode_q;
    logic [15:0]           in_count_q;
    logic [15:0]           out_count_q;
    longint unsigned       sample_pos;
    longint unsigned       bin_pos;
    longint unsigned       bound_acc;
    logic signed [15:0]    bin_pick;
    logic [16:0]           pick_mag;
    pdd_pkg::t_result      bins_expected [$];

    int                    mismatch_count = 0;
    int                    stall_pct      = 30;
    int                    gap_pct        = 30;
    int                    burst_left     = 0;
    int                    hold_req_id    = 0;
    int                    hold_seen_id   = 0;
    int                    hold_left      = 0;
    logic signed [15:0]    prev_sample    = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint unsigned series_len();
        return (in_count_q == 16'd0) ? 64'd1 : 64'(in_count_q);
    endfunction

    // Effective bin count, clipped to MaxRun bins per input sample
    function automatic longint unsigned bin_total();
        longint unsigned t;
        longint unsigned lim;
        t   = (out_count_q == 16'd0) ? 64'd1 : 64'(out_count_q);
        lim = 64'(pdd_pkg::MaxRun) * series_len();
        return (t > lim) ? lim : t;
    endfunction

    function automatic void restart_series();
        sample_pos = 0;
        bin_pos    = 0;
        bin_pick   = '0;
        pick_mag   = '0;
        bound_acc  = series_len();
    endfunction

    // Any known register restarts the series; the spare index changes nothing
    function automatic void apply_reg(input logic [pdd_pkg::IdxW-1:0] idx,
                                      input logic [15:0] data);
        case (idx)
            pdd_pkg::CfgMode:     mode_q      = data[0];
            pdd_pkg::CfgInCount:  in_count_q  = data;
            pdd_pkg::CfgOutCount: out_count_q = data;
            default:              return;
        endcase
        restart_series();
    endfunction

    // Update the open bin with one sample and queue every bin it closes
    function automatic void decimate_sample(input logic signed [15:0] x);
        longint unsigned  n;
        longint unsigned  t;
        logic [16:0]      mag;
        pdd_pkg::t_result res;
        int               count;
        int               xi;
        logic             more;
        n     = series_len();
        t     = bin_total();
        xi    = x;
        mag   = 17'(xi < 0 ? -xi : xi);
        count = 0;
        if (bound_acc < n || bound_acc - n >= sample_pos * t) begin
            bin_pick = x;
            pick_mag = mag;
        end else if (mode_q == 1'b0) begin
            if (x > bin_pick) begin
                bin_pick = x;
                pick_mag = mag;
            end
        end else if (mag > pick_mag) begin
            bin_pick = x;
            pick_mag = mag;
        end
        more = bin_pos < t && bound_acc < (sample_pos + 2) * t;
        while (more) begin
            res.value     = bin_pick;
            res.bin_index = bin_pos[15:0];
            count++;
            bin_pos++;
            bound_acc += n;
            bin_pick = x;
            pick_mag = mag;
            more = count < pdd_pkg::MaxRun && bin_pos < t
                   && bound_acc < (sample_pos + 2) * t;
            res.last = !more;
            bins_expected.insert(bins_expected.size(), res);
        end
        sample_pos++;
        if (sample_pos >= n) restart_series();
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MaxReports) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    // Mix of full-range values, small values, extremes and sign-flipped repeats
    function automatic logic signed [15:0] random_sample();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = 16'($urandom);
            5, 6:          v = 16'(int'($urandom_range(0, 6)) - 3);
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'sh7FFF;
                    1:       v = 16'sh8000;
                    2:       v = 16'sh0000;
                    default: v = 16'shFFFF;
                endcase
            end
            default:       v = 16'(-int'(prev_sample));
        endcase
        prev_sample = v;
        return v;
    endfunction

    // Offer one sample in bursts with random gaps; predict at acceptance
    task automatic send_sample(input logic signed [15:0] x);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= x;
        do @(posedge i_clk); while (!sample_ch.ready);
        decimate_sample(x);
    endtask

    // Drop valid, drain the expected results and let the pipeline empty
    task automatic settle();
        int waited;
        waited = 0;
        sample_ch.valid <= 1'b0;
        while (bins_expected.size() != 0 && waited < DrainLimit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [pdd_pkg::IdxW-1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    task automatic write_reg(input logic [pdd_pkg::IdxW-1:0] idx, input logic [15:0] data);
        settle();
        cfg_write(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] mode_word, input logic [15:0] n_word,
                              input logic [15:0] t_word);
        settle();
        cfg_write(pdd_pkg::CfgMode, mode_word);
        cfg_write(pdd_pkg::CfgInCount, n_word);
        cfg_write(pdd_pkg::CfgOutCount, t_word);
        i_cfg_we <= 1'b0;
    endtask

    // Reset values: one sample per series, one bin per series
    task automatic test_reset_values();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
    endtask

    // Maximum per bin, including the most negative value and ties
    task automatic test_max_pick();
        stall_pct = 0;
        gap_pct   = 0;
        set_config(16'hFFFE, 16'd5, 16'd2);
        send_sample(16'sh8000);
        send_sample(16'sd4);
        send_sample(16'sd4);
        send_sample(16'sd9);
        send_sample(16'sd9);
    endtask

    // Largest magnitude per bin: equal magnitudes keep the first sample
    task automatic test_magnitude_pick();
        stall_pct = 30;
        gap_pct   = 30;
        write_reg(pdd_pkg::CfgMode, 16'hFFFF);
        send_sample(16'sd7);
        send_sample(-16'sd7);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
    endtask

    // More bins than samples: one sample closes several bins
    task automatic test_upsampling();
        set_config(16'h0000, 16'd3, 16'd8);
        send_sample(16'sd3);
        send_sample(-16'sd2);
        send_sample(16'sd0);
    endtask

    // Zero in_count reads as one; bin counts clip to MaxRun per sample
    task automatic test_bin_clipping();
        set_config(16'h0001, 16'd0, 16'hFFFF);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        write_reg(pdd_pkg::CfgInCount, 16'd2);
        write_reg(pdd_pkg::CfgOutCount, 16'd200);
        send_sample(16'sd5);
        send_sample(-16'sd5);
    endtask

    // A write to the unused index must not restart the series
    task automatic test_spare_index();
        set_config(16'h0000, 16'd4, 16'd2);
        send_sample(16'sd11);
        send_sample(16'sd22);
        write_reg(CfgSpare, 16'hFFFF);
        send_sample(16'sd33);
        send_sample(16'sd4);
    endtask

    // Full-scale counts, then zero out_count, read as one bin per series
    task automatic test_extreme_counts();
        set_config(16'hFFFE, 16'hFFFF, 16'hFFFF);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample(16'sh7FFF);
        write_reg(pdd_pkg::CfgOutCount, 16'd0);
        send_sample(16'sd1);
        send_sample(16'sd2);
    endtask

    // Hold the result side off for a long stretch while samples keep coming
    task automatic test_backpressure();
        set_config(16'h0001, 16'd16, 16'd16);
        stall_pct = 0;
        gap_pct   = 0;
        hold_req_id <= hold_req_id + 1;
        repeat (40) send_sample(random_sample());
    endtask

    // Random configurations, each followed by a random run of samples
    task automatic test_random_series();
        int          sent;
        int          n_eff;
        int          lo;
        int          hi;
        int          items;
        logic [15:0] n_word;
        logic [15:0] t_word;
        sent = 0;
        while (sent < RandomItems) begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 50;
                default: stall_pct = 80;
            endcase
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 30;
                default: gap_pct = 70;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n_word = 16'($urandom_range(1, 24));
                6:                n_word = 16'd0;
                7:                n_word = 16'($urandom_range(25, 300));
                default:          n_word = 16'($urandom);
            endcase
            n_eff = (n_word == 16'd0) ? 1 : int'(n_word);
            case ($urandom_range(0, 5))
                0: t_word = 16'($urandom_range(1, n_eff));
                1: begin
                    hi = (3 * n_eff > 65535) ? 65535 : 3 * n_eff;
                    t_word = 16'($urandom_range(n_eff, hi));
                end
                2: begin
                    lo = (60 * n_eff > 65535) ? 65535 : 60 * n_eff;
                    hi = (70 * n_eff > 65535) ? 65535 : 70 * n_eff;
                    t_word = 16'($urandom_range(lo, hi));
                end
                3:       t_word = 16'd0;
                4:       t_word = 16'($urandom);
                default: t_word = 16'(n_eff);
            endcase
            if ($urandom_range(0, 3) == 0) begin
                write_reg(2'($urandom_range(0, 3)), ($urandom_range(0, 1) != 0) ? n_word : t_word);
            end else begin
                set_config(16'($urandom), n_word, t_word);
            end
            items = $urandom_range(3, 30);
            repeat (items) send_sample(random_sample());
            sent += items;
        end
    endtask

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        bin_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req_id != hold_seen_id) begin
                hold_seen_id = hold_req_id;
                hold_left    = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                bin_ch.ready <= 1'b0;
            end else begin
                bin_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Compare each result transaction with the oldest expected bin
    initial begin
        pdd_pkg::t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && bin_ch.valid && bin_ch.ready) begin
                if (bins_expected.size() == 0) begin
                    note_failure($sformatf("unexpected result value %0d bin %0d last %0d",
                                           bin_ch.value, bin_ch.bin_index, bin_ch.last));
                end else begin
                    want = bins_expected.pop_front();
                    if (bin_ch.value !== want.value || bin_ch.bin_index !== want.bin_index
                        || bin_ch.last !== want.last) begin
                        note_failure($sformatf(
                            "expected value %0d bin %0d last %0d, got value %0d bin %0d last %0d",
                            want.value, want.bin_index, want.last,
                            bin_ch.value, bin_ch.bin_index, bin_ch.last));
                    end
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("peak_detect_decimator_core test failed");
        $finish;
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= pdd_pkg::CfgMode;
        i_cfg_data       <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        mode_q      = 1'b0;
        in_count_q  = 16'd1;
        out_count_q = 16'd1;
        restart_series();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_max_pick();
        test_magnitude_pick();
        test_upsampling();
        test_bin_clipping();
        test_spare_index();
        test_extreme_counts();
        test_backpressure();
        test_random_series();

        settle();
        if (mismatch_count == 0 && bins_expected.size() == 0) begin
            $display("peak_detect_decimator_core test passed");
        end else begin
            $display("peak_detect_decimator_core test failed");
        end
        $finish;
    end

endmodule

// File: peak_detect_decimator_core.f
+incdir+rtl
rtl/pdd_pkg.sv
rtl/pdd_in_if.sv
rtl/pdd_out_if.sv
rtl/pdd_cfg.sv
rtl/pdd_front.sv
rtl/pdd_fifo.sv
rtl/pdd_back.sv
rtl/peak_detect_decimator_core.sv
tb/sv/tb_peak_detect_decimator_core.sv
